>>> sv/nearest_palette_color_quantizer_top_macros.svh
// Assertion macros for the nearest palette color quantizer.
`ifndef NEAREST_PALETTE_COLOR_QUANTIZER_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_QUANTIZER_TOP_MACROS_SVH

// Check an implication on every edge outside reset.
`define NPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npq implication check failed");

// Check an implication on every edge, reset included.
`define NPQ_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("npq check failed");

`endif

>>> sv/npq_pkg.sv
// Shared types, constants and helpers of the nearest palette color quantizer.
`default_nettype none
package npq_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int CHAN_W  = 8;
  localparam int ECH_W   = 5;
  localparam int ENTRY_W = 3 * ECH_W;
  localparam int IDX_W   = 8;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int DIST_W  = SQ_W + 2;

  typedef enum logic {
    CMD_WRITE    = 1'b0,
    CMD_QUANTIZE = 1'b1
  } cmd_t;

  // Item traveling along the cell chain with the running best match
  typedef struct packed {
    logic              vld;
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_d;
  } npq_pkt_t;

  // Square of the difference between a stored channel and a pixel channel
  function automatic logic [SQ_W-1:0] npq_sq_diff(input logic [ECH_W-1:0] e,
                                                  input logic [CHAN_W-1:0] p);
    logic [CHAN_W-1:0] ev;
    logic [CHAN_W-1:0] d;
    ev = {e, {(CHAN_W - ECH_W){1'b0}}};
    d  = (ev > p) ? (ev - p) : (p - ev);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage
`default_nettype wire

>>> sv/npq_ifs.sv
// Valid/ready channel interfaces for pixel items and index results.
`default_nettype none
interface npq_in_if;
  import npq_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [IDX_W-1:0]  entry_index;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  modport source(output valid, command, entry_index, red, green, blue, input ready);
  modport sink(input valid, command, entry_index, red, green, blue, output ready);
endinterface

interface npq_out_if;
  import npq_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] palette_index;
  modport source(output valid, palette_index, input ready);
  modport sink(input valid, palette_index, output ready);
endinterface
`default_nettype wire

>>> sv/npq_cell.sv
// One chain cell: holds a palette entry and updates the running nearest match.
`default_nettype none
module npq_cell
  import npq_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire npq_pkt_t pkt_i,
  output npq_pkt_t      pkt_o
);

  typedef struct packed {
    npq_pkt_t                 pkt;
    logic [2:0][SQ_W-1:0]     sq;
  } mid_t;

  logic [ENTRY_W-1:0]   entry_r, entry_nxt;
  logic [2:0][SQ_W-1:0] sq_nxt;
  mid_t                 mid_r;
  npq_pkt_t             out_r, out_nxt;
  logic [DIST_W-1:0]    sum_d;
  logic                 wr_hit;

  // Capture a write aimed at this entry; entry zero stays black
  assign wr_hit = pkt_i.vld && (pkt_i.cmd == CMD_WRITE) && (CELL_IDX != 0)
                  && (pkt_i.idx == IDX_W'(CELL_IDX));

  always_comb begin
    entry_nxt = entry_r;
    if (wr_hit) begin
      entry_nxt = {pkt_i.r[CHAN_W-1 -: ECH_W], pkt_i.g[CHAN_W-1 -: ECH_W],
                   pkt_i.b[CHAN_W-1 -: ECH_W]};
    end
  end

  // Square the per-channel differences against the stored entry
  always_comb begin
    sq_nxt[0] = npq_sq_diff(entry_r[2*ECH_W +: ECH_W], pkt_i.r);
    sq_nxt[1] = npq_sq_diff(entry_r[ECH_W +: ECH_W], pkt_i.g);
    sq_nxt[2] = npq_sq_diff(entry_r[0 +: ECH_W], pkt_i.b);
  end

  // Sum the squares and keep the strictly smaller distance
  assign sum_d = DIST_W'(mid_r.sq[0]) + DIST_W'(mid_r.sq[1]) + DIST_W'(mid_r.sq[2]);

  always_comb begin
    out_nxt = mid_r.pkt;
    if ((CELL_IDX == 0) || (sum_d < mid_r.pkt.best_d)) begin
      out_nxt.best_d   = sum_d;
      out_nxt.best_idx = IDX_W'(CELL_IDX);
    end
  end

  // Advance both stages when the chain moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r       <= '0;
      mid_r.pkt.vld <= 1'b0;
      out_r.vld     <= 1'b0;
    end else if (en) begin
      entry_r   <= entry_nxt;
      mid_r.pkt <= pkt_i;
      mid_r.sq  <= sq_nxt;
      out_r     <= out_nxt;
    end
  end

  assign pkt_o = out_r;

endmodule
`default_nettype wire

>>> sv/nearest_palette_color_quantizer_top.sv
// Each chain cell registers items in mid_r, then out_r; an output register follows the chain.
// Throughput: one item per cycle unless stalled; each cell holds one entry, passing items on.
// Writes travel the chain in order with pixels, so each pixel sees exactly the earlier writes.
// A stalled output register freezes the whole chain; ready drops only while it is stalled.
// Reset (synchronous, active low) clears every palette entry to black and empties the chain.
`default_nettype none
`include "nearest_palette_color_quantizer_top_macros.svh"
module nearest_palette_color_quantizer_top
  import npq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  npq_in_if.sink      in_chan,
  npq_out_if.source   out_chan
);

  npq_pkt_t         chain [PALETTE_ENTRIES+1];
  logic             en;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  npq_pkt_t         last;

  // Move the chain unless a finished result is still waiting
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // Build the item entering the chain
  always_comb begin
    chain[0]          = '0;
    chain[0].vld      = in_chan.valid;
    chain[0].cmd      = cmd_t'(in_chan.command);
    chain[0].idx      = in_chan.entry_index;
    chain[0].r        = in_chan.red;
    chain[0].g        = in_chan.green;
    chain[0].b        = in_chan.blue;
  end

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npq_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .pkt_i(chain[i]),
      .pkt_o(chain[i+1])
    );
  end

  assign last = chain[PALETTE_ENTRIES];

  // Register the result of quantize items; drop writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.vld && (last.cmd == CMD_QUANTIZE);
      out_idx_r   <= last.best_idx;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.palette_index = out_idx_r;

  `NPQ_ASSERT_IMPL(a_stall_only_on_full_output, !in_chan.ready, out_valid_r && !out_chan.ready)
  `NPQ_ASSERT_IMPL(a_index_in_range, out_valid_r,
                   32'(out_idx_r) < 32'(PALETTE_ENTRIES))
  `NPQ_ASSERT_ALWAYS(a_empty_after_reset, !rst_n, ##1 !out_valid_r)

endmodule
`default_nettype wire
